// ===== sv/fpa_pkg.sv =====
// Package with the shared types, constants and codes of the identifier allocator.
package fpa_pkg;

  // Sizes of the identifier space and the stored handles.
  localparam int NUM_IDS     = 64;
  localparam int HANDLE_BITS = 32;
  localparam int ID_W        = 6;
  localparam int IDX_W       = $clog2(NUM_IDS);
  localparam int CNT_W       = $clog2(NUM_IDS + 1);
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_IDS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(NUM_IDS);

  // Operation codes carried by an input item.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  // Status codes returned with each result item.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  // Control states of the item sequencer.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Command from the sequencer to the free list.
  typedef struct packed {
    logic             rd;
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_id;
  } fl_cmd_t;

  // Status from the free list to the sequencer.
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [IDX_W-1:0] pop_id;
  } fl_stat_t;

endpackage

// ===== sv/fpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fpa_free_list.sv =====
// Circular free list of identifiers kept in a RAM with head, tail and count.
module fpa_free_list
  import fpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  fl_cmd_t  cmd,
  output fl_stat_t stat
);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rd_slot_r;
  logic             rd_valid_r;
  logic [NUM_IDS-1:0] slot_valid_r;
  logic [IDX_W-1:0] ram_rdata;

  // Storage for the queued identifiers.
  fpa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(NUM_IDS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(tail_r),
    .wdata(cmd.push_id),
    .re   (cmd.rd),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  // Pointer and count updates; an item either pops or pushes, never both.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (cmd.push) begin
      tail_nxt  = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= FULL_CNT;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Slots never written read as their own index, the reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (cmd.push) begin
      slot_valid_r[tail_r] <= 1'b1;
    end
  end

  // Remember which slot was read and whether it held written data.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_slot_r  <= head_r;
      rd_valid_r <= slot_valid_r[head_r];
    end
  end

  assign stat.empty  = (count_r == '0);
  assign stat.full   = (count_r == FULL_CNT);
  assign stat.pop_id = rd_valid_r ? ram_rdata : rd_slot_r;

endmodule

// ===== sv/pid_free_list_allocator_unit.sv =====
// Top level of the identifier allocator: sequencer, handle table and free list.
//
// Input channel (in_valid/in_ready) carries one operation per item:
// allocate, lookup or release, with an identifier and a handle.
// Result channel (out_valid/out_ready) returns exactly one item per input
// item, in order: the granted or echoed identifier, the handle found on
// lookup and a status code.
// For each item, the accept cycle issues the reads of the
// free-list RAM and the handle-table RAM, and the execute state then uses the read
// data, writes both RAMs back and loads the output register. The registered
// RAM read sets this split; a new item is taken only once the sequencer is
// back in idle, so one item is finished before the next is accepted.
// The output register holds one finished result, so the next item is
// accepted while that result waits. If the receiver stalls, the item in
// progress waits in the execute state until the output register frees.
// A synchronous reset makes every identifier free in ascending order and
// clears all handles; both take effect at once through per-entry valid bits,
// so the block accepts items as soon as reset is released.
module pid_free_list_allocator_unit
  import fpa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [ID_W-1:0]        in_id_in,
  input  logic [HANDLE_BITS-1:0] in_handle_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ID_W-1:0]        out_id_out,
  output logic [HANDLE_BITS-1:0] out_handle_out,
  output logic [STATUS_W-1:0]    out_status
);

  state_t state_r, state_nxt;
  logic   accept;
  logic   out_free;
  logic   exec_go;

  logic [FUNC_W-1:0]      func_r;
  logic [ID_W-1:0]        id_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic                   tbl_hit_r;
  logic [NUM_IDS-1:0]     tbl_valid_r;

  logic                   tbl_we;
  logic [IDX_W-1:0]       tbl_waddr;
  logic [HANDLE_BITS-1:0] tbl_wdata;
  logic [HANDLE_BITS-1:0] tbl_rdata;
  logic                   in_range;

  logic [ID_W-1:0]        res_id;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [STATUS_W-1:0]    res_status;

  logic                   out_valid_r;
  logic [ID_W-1:0]        out_id_r;
  logic [HANDLE_BITS-1:0] out_handle_r;
  logic [STATUS_W-1:0]    out_status_r;

  fl_cmd_t  fl_cmd;
  fl_stat_t fl_stat;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: exec_go  = out_free;
      default: begin
        in_ready = 1'b0;
        exec_go  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item and whether its table entry holds written data.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_func;
      id_r      <= in_id_in;
      handle_r  <= in_handle_in;
      tbl_hit_r <= tbl_valid_r[IDX_W'(in_id_in)];
    end
  end

  // Handle table storage.
  fpa_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(NUM_IDS)
  ) u_handle_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re   (accept),
    .raddr(IDX_W'(in_id_in)),
    .rdata(tbl_rdata)
  );

  // Entries never written read as zero, meaning no handle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_valid_r <= '0;
    end else if (tbl_we) begin
      tbl_valid_r[tbl_waddr] <= 1'b1;
    end
  end

  // Free list of identifiers.
  fpa_free_list u_free_list (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (fl_cmd),
    .stat (fl_stat)
  );

  assign in_range = (32'(id_r) < 32'(NUM_IDS));

  // Operation: result fields and the write-back to both memories.
  always_comb begin
    res_id         = id_r;
    res_handle     = '0;
    res_status     = STATUS_OK;
    tbl_we         = 1'b0;
    tbl_waddr      = IDX_W'(id_r);
    tbl_wdata      = '0;
    fl_cmd.rd      = accept;
    fl_cmd.pop     = 1'b0;
    fl_cmd.push    = 1'b0;
    fl_cmd.push_id = IDX_W'(id_r);
    case (func_r)
      FUNC_ALLOC: begin
        if (fl_stat.empty) begin
          res_status = STATUS_NO_FREE;
        end else begin
          res_id     = ID_W'(fl_stat.pop_id);
          fl_cmd.pop = exec_go;
          tbl_we     = exec_go;
          tbl_waddr  = fl_stat.pop_id;
          tbl_wdata  = handle_r;
        end
      end
      FUNC_LOOKUP: begin
        if (in_range && tbl_hit_r) res_handle = tbl_rdata;
      end
      FUNC_RELEASE: begin
        if (in_range) begin
          tbl_we = exec_go;
          if (fl_stat.full) begin
            res_status = STATUS_FULL;
          end else begin
            fl_cmd.push = exec_go;
          end
        end
      end
      default: res_status = STATUS_OK;
    endcase
  end

  // Output register; it takes a new result when empty or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_id_r     <= res_id;
      out_handle_r <= res_handle;
      out_status_r <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_id_out     = out_id_r;
  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;

endmodule

// ===== sv/fpa_checker.sv =====
// Port-level checks of the identifier allocator and their binding to the top level.
module fpa_checker
  import fpa_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [ID_W-1:0]        out_id_out,
  input logic [HANDLE_BITS-1:0] out_handle_out,
  input logic [STATUS_W-1:0]    out_status
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_id_out)
      && $stable(out_handle_out) && $stable(out_status))
    else $error("result item changed while stalled");

  // Items are worked one at a time: no accept right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input item accepted while another is in progress");

  // A failed allocate or release never reports a handle.
  a_err_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_NO_FREE || out_status == STATUS_FULL)
      |-> out_handle_out == '0)
    else $error("error result carries a handle");

  // Reset empties the result channel.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pid_free_list_allocator_unit fpa_checker u_fpa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_id_out    (out_id_out),
  .out_handle_out(out_handle_out),
  .out_status    (out_status)
);
